FILE: rtl/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and helpers for the key/value table core.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int ENTRIES   = 16;
	localparam int KEY_BYTES = 8;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	// request operations
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_GET    = 2'd2;
	localparam logic [1:0] FUNC_RESET  = 2'd3;

	// response status codes
	localparam logic [3:0] ST_UPDATED = 4'd0;
	localparam logic [3:0] ST_ADDED   = 4'd1;
	localparam logic [3:0] ST_EMPTY   = 4'd2;
	localparam logic [3:0] ST_FULL    = 4'd3;
	localparam logic [3:0] ST_REMOVED = 4'd4;
	localparam logic [3:0] ST_RMISS   = 4'd5;
	localparam logic [3:0] ST_FOUND   = 4'd6;
	localparam logic [3:0] ST_GMISS   = 4'd7;
	localparam logic [3:0] ST_CLEARED = 4'd8;

	typedef struct packed {
		logic [1:0]              func;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [3:0]              status;
		logic signed [VAL_W-1:0] value_out;
		logic [4:0]              entry_count;
	} rsp_t;

	typedef enum logic [1:0] {RD_SCAN, RD_HIT, RD_LAST} rd_sel_t;
	typedef enum logic [1:0] {WR_UPDATE, WR_APPEND, WR_MOVE} wr_op_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;
	typedef enum logic [1:0] {VAL_ZERO, VAL_INPUT, VAL_READ} val_sel_t;

	typedef struct packed {
		logic       load_req;
		logic       scan;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_op_t     wr_op;
		cnt_op_t    cnt_op;
		logic       load_rsp;
		logic [3:0] rsp_status;
		val_sel_t   val_sel;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic key_empty;
		logic full;
	} sts_t;

	// key ends at its first zero byte and holds at most KEY_BYTES bytes
	function automatic logic [KEY_W-1:0] norm_key(logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] acc;
		logic             live;
		acc  = '0;
		live = 1'b1;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (i >= KEY_BYTES || raw[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				acc[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return acc;
	endfunction

endpackage

FILE: rtl/key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_core
// Bounded key/value table of ENTRIES pairs with update, remove, get and reset.
// One request is worked at a time and gives one response item. A request
// runs through the key scan, which compares one stored key per cycle
// through the single read port of the key memory and ends early when the
// key hits, then one entry read (remove, get on a hit) and a write-back
// step; a reset request goes straight to the write-back step. The
// write-back step waits while the previous response is still unaccepted.
// The response sits in an output register, so a new request is taken while
// the previous response is still waiting.
// ----------------------------------------------------------------------------
module key_value_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kvt_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output kvt_pkg::rsp_t out_data
);

	kvt_pkg::cmd_t cmd;
	kvt_pkg::sts_t sts;

	kvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_func   (in_data.func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kvt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	// busy after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a request while the previous one was in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.entry_count <= 5'(kvt_pkg::ENTRIES)))
		else $error("entry count beyond table size");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == kvt_pkg::ST_FULL)
		|-> (out_data.entry_count == 5'(kvt_pkg::ENTRIES)))
		else $error("full status with free entries");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == kvt_pkg::ST_GMISS
			|| out_data.status == kvt_pkg::ST_RMISS
			|| out_data.status == kvt_pkg::ST_CLEARED))
		|-> (out_data.value_out == '0))
		else $error("nonzero value on miss or reset");

	a_cleared_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == kvt_pkg::ST_CLEARED)
		|-> (out_data.entry_count == '0))
		else $error("table not empty after reset request");

endmodule

FILE: rtl/kvt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_dp
// Datapath: key and value memories, entry count, scan compare and the
// response register.
// ----------------------------------------------------------------------------
module kvt_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  kvt_pkg::req_t in_data,
	input  kvt_pkg::cmd_t cmd,
	output kvt_pkg::sts_t sts,
	output kvt_pkg::rsp_t out_data
);

	logic [kvt_pkg::KEY_W-1:0]        key_mem [kvt_pkg::ENTRIES];
	logic signed [kvt_pkg::VAL_W-1:0] val_mem [kvt_pkg::ENTRIES];

	logic [kvt_pkg::KEY_W-1:0]        key_q;
	logic signed [kvt_pkg::VAL_W-1:0] value_q;
	logic [kvt_pkg::CNT_W-1:0]        count_q;
	logic [kvt_pkg::CNT_W-1:0]        scan_idx_q;
	logic                             cmp_v_q;
	logic [kvt_pkg::IDX_W-1:0]        cmp_idx_q;
	logic                             hit_q;
	logic [kvt_pkg::IDX_W-1:0]        hit_slot_q;
	logic [kvt_pkg::KEY_W-1:0]        rd_key_q;
	logic signed [kvt_pkg::VAL_W-1:0] rd_val_q;
	kvt_pkg::rsp_t                    rsp_q;

	logic [kvt_pkg::IDX_W-1:0]        rd_addr;
	logic [kvt_pkg::IDX_W-1:0]        wr_addr;
	logic [kvt_pkg::KEY_W-1:0]        wr_key_data;
	logic signed [kvt_pkg::VAL_W-1:0] wr_val_data;
	logic                             wr_key;
	logic [kvt_pkg::CNT_W-1:0]        cnt_next;
	logic signed [kvt_pkg::VAL_W-1:0] val_sel_data;
	logic                             scan_more;
	logic                             match;

	assign scan_more = scan_idx_q < count_q;
	assign match     = cmp_v_q && !hit_q && (key_q != '0) && (rd_key_q == key_q);

	assign sts.scan_done = hit_q || (!scan_more && !cmp_v_q);
	assign sts.hit       = hit_q;
	assign sts.key_empty = key_q == '0;
	assign sts.full      = count_q >= kvt_pkg::CNT_W'(kvt_pkg::ENTRIES);

	always_comb begin
		unique case (cmd.rd_sel)
			kvt_pkg::RD_HIT:  rd_addr = hit_slot_q;
			kvt_pkg::RD_LAST: rd_addr = kvt_pkg::IDX_W'(count_q - kvt_pkg::CNT_W'(1));
			default:          rd_addr = scan_idx_q[kvt_pkg::IDX_W-1:0];
		endcase
	end

	always_comb begin
		unique case (cmd.wr_op)
			kvt_pkg::WR_APPEND: begin
				wr_addr     = count_q[kvt_pkg::IDX_W-1:0];
				wr_key      = 1'b1;
				wr_key_data = key_q;
				wr_val_data = value_q;
			end
			kvt_pkg::WR_MOVE: begin
				// last entry fills the hole; a self-move rewrites the same data
				wr_addr     = hit_slot_q;
				wr_key      = 1'b1;
				wr_key_data = rd_key_q;
				wr_val_data = rd_val_q;
			end
			default: begin
				wr_addr     = hit_slot_q;
				wr_key      = 1'b0;
				wr_key_data = key_q;
				wr_val_data = value_q;
			end
		endcase
	end

	always_comb begin
		unique case (cmd.cnt_op)
			kvt_pkg::CNT_INC: cnt_next = count_q + kvt_pkg::CNT_W'(1);
			kvt_pkg::CNT_DEC: cnt_next = count_q - kvt_pkg::CNT_W'(1);
			kvt_pkg::CNT_CLR: cnt_next = '0;
			default:          cnt_next = count_q;
		endcase
	end

	always_comb begin
		unique case (cmd.val_sel)
			kvt_pkg::VAL_INPUT: val_sel_data = value_q;
			kvt_pkg::VAL_READ:  val_sel_data = rd_val_q;
			default:            val_sel_data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			if (wr_key) begin
				key_mem[wr_addr] <= wr_key_data;
			end
			val_mem[wr_addr] <= wr_val_data;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q   <= kvt_pkg::norm_key(in_data.key);
			value_q <= in_data.value_in;
		end
		if (match) begin
			hit_slot_q <= cmp_idx_q;
		end
		if (cmd.scan) begin
			cmp_idx_q <= scan_idx_q[kvt_pkg::IDX_W-1:0];
		end
		if (cmd.load_rsp) begin
			rsp_q.status      <= cmd.rsp_status;
			rsp_q.value_out   <= val_sel_data;
			rsp_q.entry_count <= 5'(cnt_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_v_q    <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			count_q <= cnt_next;
			if (cmd.load_req) begin
				scan_idx_q <= '0;
				cmp_v_q    <= 1'b0;
				hit_q      <= 1'b0;
			end else begin
				if (cmd.scan && scan_more && !hit_q) begin
					scan_idx_q <= scan_idx_q + kvt_pkg::CNT_W'(1);
					cmp_v_q    <= 1'b1;
				end else begin
					cmp_v_q <= 1'b0;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	assign out_data = rsp_q;

endmodule

FILE: rtl/kvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_ctrl
// Request sequencer: accept, key scan, entry read, update and response.
// ----------------------------------------------------------------------------
module kvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_func,
	output logic          out_valid,
	input  logic          out_ready,
	input  kvt_pkg::sts_t sts,
	output kvt_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {IDLE, SCAN, READ, ACT} state_t;

	state_t     state_q;
	logic [1:0] func_q;
	logic       out_valid_q;
	logic       rsp_free;

	assign rsp_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = kvt_pkg::RD_SCAN;
		cmd.wr_op      = kvt_pkg::WR_UPDATE;
		cmd.cnt_op     = kvt_pkg::CNT_HOLD;
		cmd.val_sel    = kvt_pkg::VAL_ZERO;
		cmd.rsp_status = kvt_pkg::ST_CLEARED;
		unique case (state_q)
			IDLE: begin
				cmd.load_req = in_valid;
			end
			SCAN: begin
				cmd.scan  = 1'b1;
				cmd.rd_en = 1'b1;
			end
			READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = (func_q == kvt_pkg::FUNC_REMOVE) ? kvt_pkg::RD_LAST
					: kvt_pkg::RD_HIT;
			end
			ACT: begin
				// nothing commits until the response register can take the item
				cmd.load_rsp = rsp_free;
				unique case (func_q)
					kvt_pkg::FUNC_UPDATE: begin
						cmd.val_sel = kvt_pkg::VAL_INPUT;
						priority if (sts.key_empty) begin
							cmd.rsp_status = kvt_pkg::ST_EMPTY;
						end else if (sts.hit) begin
							cmd.wr_en      = rsp_free;
							cmd.wr_op      = kvt_pkg::WR_UPDATE;
							cmd.rsp_status = kvt_pkg::ST_UPDATED;
						end else if (sts.full) begin
							cmd.rsp_status = kvt_pkg::ST_FULL;
						end else begin
							cmd.wr_en      = rsp_free;
							cmd.wr_op      = kvt_pkg::WR_APPEND;
							cmd.cnt_op     = rsp_free ? kvt_pkg::CNT_INC : kvt_pkg::CNT_HOLD;
							cmd.rsp_status = kvt_pkg::ST_ADDED;
						end
					end
					kvt_pkg::FUNC_REMOVE: begin
						if (sts.hit) begin
							cmd.wr_en      = rsp_free;
							cmd.wr_op      = kvt_pkg::WR_MOVE;
							cmd.cnt_op     = rsp_free ? kvt_pkg::CNT_DEC : kvt_pkg::CNT_HOLD;
							cmd.rsp_status = kvt_pkg::ST_REMOVED;
						end else begin
							cmd.rsp_status = kvt_pkg::ST_RMISS;
						end
					end
					kvt_pkg::FUNC_GET: begin
						if (sts.hit) begin
							cmd.val_sel    = kvt_pkg::VAL_READ;
							cmd.rsp_status = kvt_pkg::ST_FOUND;
						end else begin
							cmd.rsp_status = kvt_pkg::ST_GMISS;
						end
					end
					default: begin
						cmd.cnt_op     = rsp_free ? kvt_pkg::CNT_CLR : kvt_pkg::CNT_HOLD;
						cmd.rsp_status = kvt_pkg::ST_CLEARED;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			func_q      <= kvt_pkg::FUNC_UPDATE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ACT && rsp_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						func_q  <= in_func;
						state_q <= (in_func == kvt_pkg::FUNC_RESET) ? ACT : SCAN;
					end
				end
				SCAN: begin
					if (sts.scan_done) begin
						if (sts.hit && (func_q == kvt_pkg::FUNC_REMOVE
								|| func_q == kvt_pkg::FUNC_GET)) begin
							state_q <= READ;
						end else begin
							state_q <= ACT;
						end
					end
				end
				READ: begin
					state_q <= ACT;
				end
				ACT: begin
					if (rsp_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

FILE: test/key_value_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_checker
// Watches both channels of the key/value table core. Every accepted request is
// run through a behavioral copy of the table, and the response it should give
// is queued. Every accepted response is compared field by field with the
// oldest queued one. Mismatches, and responses with nothing outstanding, are
// counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module key_value_table_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  kvt_pkg::req_t in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  kvt_pkg::rsp_t out_data,
	output int            errors,
	output int            pending,
	output int            checked
);
	import kvt_pkg::*;

	logic [KEY_W-1:0] keys_held [ENTRIES];
	logic [VAL_W-1:0] vals_held [ENTRIES];
	int               fill;
	rsp_t             rsp_due [$];
	rsp_t             want;

	initial begin
		fill    = 0;
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	// key stops at the first zero byte; nothing past it counts
	function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
		logic [KEY_W-1:0] k;
		logic             ended;
		k     = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				k[8*i +: 8] = raw[8*i +: 8];
		end
		return k;
	endfunction

	// updates the shadow table and returns the response the request gives
	function automatic rsp_t apply_request(req_t r);
		rsp_t             o;
		logic [KEY_W-1:0] k;
		int               hit;
		k   = trim_key(r.key);
		hit = -1;
		if (k != '0) begin
			for (int i = fill - 1; i >= 0; i--)
				if (keys_held[i] == k)
					hit = i;
		end
		o.status    = ST_CLEARED;
		o.value_out = '0;
		case (r.func)
		FUNC_UPDATE: begin
			o.value_out = r.value_in;
			if (k == '0) begin
				o.status = ST_EMPTY;
			end else if (hit >= 0) begin
				vals_held[hit] = r.value_in;
				o.status       = ST_UPDATED;
			end else if (fill >= ENTRIES) begin
				o.status = ST_FULL;
			end else begin
				keys_held[fill] = k;
				vals_held[fill] = r.value_in;
				fill++;
				o.status = ST_ADDED;
			end
		end
		FUNC_REMOVE: begin
			if (hit >= 0) begin
				// last entry fills the hole
				keys_held[hit] = keys_held[fill-1];
				vals_held[hit] = vals_held[fill-1];
				fill--;
				o.status = ST_REMOVED;
			end else begin
				o.status = ST_RMISS;
			end
		end
		FUNC_GET: begin
			if (hit >= 0) begin
				o.value_out = vals_held[hit];
				o.status    = ST_FOUND;
			end else begin
				o.status = ST_GMISS;
			end
		end
		default: begin
			fill     = 0;
			o.status = ST_CLEARED;
		end
		endcase
		o.entry_count = 5'(fill);
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				rsp_due.push_back(apply_request(in_data));
			if (out_valid && out_ready) begin
				if (rsp_due.size() == 0) begin
					if (errors < 10)
						$display("checker: unexpected response status %0d value %0d count %0d",
							out_data.status, out_data.value_out, out_data.entry_count);
					errors++;
				end else begin
					want = rsp_due.pop_front();
					checked++;
					if (out_data.status !== want.status ||
						out_data.value_out !== want.value_out ||
						out_data.entry_count !== want.entry_count) begin
						if (errors < 10)
							$display("checker: response %0d: want st %0d val %0d cnt %0d, got st %0d val %0d cnt %0d",
								checked, want.status, want.value_out, want.entry_count,
								out_data.status, out_data.value_out, out_data.entry_count);
						errors++;
					end
				end
			end
			pending = rsp_due.size();
		end
	end

endmodule

FILE: test/tb_key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_table_core
// Drives the key/value table core with a directed set of requests covering
// empty keys, padded keys, a full table and the removal paths, then with
// random requests over a small key pool in four idle/stall patterns. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_key_value_table_core;
	import kvt_pkg::*;

	localparam int POOL        = 20;
	localparam int PHASE_ITEMS = 163;
	localparam int CYCLE_LIMIT = 400000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	req_t             in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	rsp_t             out_data;
	int               n_errors;
	int               n_pending;
	int               n_checked;
	int               idle_pct    = 0;
	int               stall_pct   = 0;
	int               cycle_count = 0;
	int               sent [4]    = '{0, 0, 0, 0};
	logic [KEY_W-1:0] key_pool [POOL];
	int               key_len [POOL];
	req_t             directed [$];

	always #5 clk = ~clk;

	key_value_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	key_value_table_checker u_monitor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (n_errors),
		.pending   (n_pending),
		.checked   (n_checked)
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic req_t mk_req(logic [1:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		req_t r;
		r.func     = f;
		r.key      = k;
		r.value_in = v;
		return r;
	endfunction

	// mostly pool keys, some with junk past the terminator; a few random or empty
	function automatic logic [KEY_W-1:0] rand_key();
		int               r;
		int               p;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, POOL - 1);
		k = key_pool[p];
		if (r < 8)
			k = {$urandom, $urandom};
		else if (r < 13)
			k = {$urandom, $urandom} & ~64'hFF;
		else if (r < 40 && key_len[p] < 7)
			k = k | ({$urandom, $urandom} << (8 * (key_len[p] + 1)));
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 99);
		case (r)
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0;
		3: return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	task automatic send(req_t r);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		sent[r.func]++;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every outstanding response is back
	task automatic drain();
		in_valid <= 1'b0;
		wait (n_pending == 0);
		@(negedge clk);
	endtask

	initial begin
		int         r;
		int         n;
		logic [1:0] f;
		key_pool[0] = '1;
		key_len[0]  = 8;
		key_pool[1] = 64'h01;
		key_len[1]  = 1;
		for (int p = 2; p < POOL; p++) begin
			n           = $urandom_range(1, 8);
			key_len[p]  = n;
			key_pool[p] = '0;
			for (int b = 0; b < n; b++)
				key_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: misses and a clear with nothing stored
		directed.push_back(mk_req(FUNC_GET, 64'h01, 32'h0));
		directed.push_back(mk_req(FUNC_REMOVE, 64'h01, 32'h0));
		directed.push_back(mk_req(FUNC_RESET, 64'h0, 32'h0));
		// empty keys, plain and with junk above a zero low byte; then two keys added, one updated
		directed.push_back(mk_req(FUNC_UPDATE, 64'h0, 32'h5));
		directed.push_back(mk_req(FUNC_UPDATE, 64'hDEAD_BEEF_0000_1200, 32'h6));
		directed.push_back(mk_req(FUNC_UPDATE, '1, 32'h7FFF_FFFF));
		directed.push_back(mk_req(FUNC_UPDATE, 64'h01, 32'h8000_0000));
		directed.push_back(mk_req(FUNC_UPDATE, 64'h01, 32'hFFFF_FFFF));
		// same key once trimmed
		directed.push_back(mk_req(FUNC_GET, 64'hA5A5_0000_0000_0001, 32'h1234));
		directed.push_back(mk_req(FUNC_UPDATE, 64'h00FF_0000_0000_0042, 32'h42));
		for (int i = 0; i < 13; i++)
			directed.push_back(mk_req(FUNC_UPDATE, 64'(8'h61 + i), 32'(i * 1000 - 5000)));
		// table is full now
		directed.push_back(mk_req(FUNC_UPDATE, 64'h7A, 32'h77));
		directed.push_back(mk_req(FUNC_UPDATE, 64'h61, 32'h99));
		directed.push_back(mk_req(FUNC_GET, 64'h0, 32'h0));
		// first slot, refilled from the last; then the last slot itself
		directed.push_back(mk_req(FUNC_REMOVE, '1, 32'h0));
		directed.push_back(mk_req(FUNC_REMOVE, 64'h6C, 32'h0));
		directed.push_back(mk_req(FUNC_REMOVE, 64'h0, 32'h0));
		directed.push_back(mk_req(FUNC_RESET, 64'hFFFF, 32'h1));
		foreach (directed[i])
			send(directed[i]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 70;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 70;
			end
			default: begin
				idle_pct  = 14;
				stall_pct = 14;
			end
			endcase
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					f = FUNC_UPDATE;
				else if (r < 70)
					f = FUNC_REMOVE;
				else if (r < 96)
					f = FUNC_GET;
				else
					f = FUNC_RESET;
				send(mk_req(f, rand_key(), rand_value()));
			end
			drain();
		end
		stall_pct = 0;
		repeat (40) @(negedge clk);

		$display("summary: %0d requests (%0d update, %0d remove, %0d get, %0d reset), %0d responses checked",
			sent[0] + sent[1] + sent[2] + sent[3], sent[FUNC_UPDATE], sent[FUNC_REMOVE],
			sent[FUNC_GET], sent[FUNC_RESET], n_checked);
		$display("summary: directed corner cases, then four idle/stall patterns with a drain between each");
		if (n_errors == 0 && n_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/kvt_pkg.sv
rtl/kvt_dp.sv
rtl/kvt_ctrl.sv
rtl/key_value_table_core.sv
test/key_value_table_checker.sv
test/tb_key_value_table_core.sv
